// File: rtl/core/rtpl_pkg.sv
// Shared types and constants for the route table predecessor lookup core.
package rtpl_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned ConnW    = 8;
  localparam int unsigned ConnBits = 8;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpFind   = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StPresent = 2'd1;
  localparam logic [1:0] StAbsent  = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    logic [ConnW-1:0] conn;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ConnW-1:0] found_conn;
    logic             found;
    logic             set_ok;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [KeyW-1:0]  key;
    logic [ConnW-1:0] conn;
  } wr_t;
endpackage

// File: rtl/core/rtpl_ram.sv
// Entry memory: key and handle per slot, one write port, one registered read port.
module rtpl_ram (
  input  logic                      clk_i,
  input  rtpl_pkg::wr_t             wr_i,
  input  logic [rtpl_pkg::IdxW-1:0] raddr_i,
  output logic [rtpl_pkg::KeyW-1:0] rkey_o,
  output logic [rtpl_pkg::ConnW-1:0] rconn_o
);
  import rtpl_pkg::*;

  logic [KeyW-1:0]  key_mem  [Capacity];
  logic [ConnW-1:0] conn_mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      key_mem[wr_i.addr]  <= wr_i.key;
      conn_mem[wr_i.addr] <= wr_i.conn;
    end
    rkey_o  <= key_mem[raddr_i];
    rconn_o <= conn_mem[raddr_i];
  end
endmodule

// File: rtl/core/rtpl_ctrl.sv
// Scan sequencer: walks all slots once per item and builds the result.
module rtpl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  rtpl_pkg::req_t             req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output rtpl_pkg::rsp_t             rsp_o,
  output rtpl_pkg::wr_t              wr_o,
  output logic [rtpl_pkg::IdxW-1:0]  raddr_o,
  input  logic [rtpl_pkg::KeyW-1:0]  rkey_i,
  input  logic [rtpl_pkg::ConnW-1:0] rconn_i
);
  import rtpl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rv_q, rv_d;
  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [Capacity-1:0] valid_q, valid_d;
  logic             hit_q, hit_d, free_q, free_d, pred_q, pred_d, top_q, top_d;
  logic [IdxW-1:0]  hidx_q, hidx_d, fidx_q, fidx_d;
  logic [ConnW-1:0] hconn_q, hconn_d, pconn_q, pconn_d, tconn_q, tconn_d;
  logic [KeyW-1:0]  pkey_q, pkey_d, tkey_q, tkey_d;
  logic             any_q, any_d;
  logic             ovalid_q, ovalid_d;
  rsp_t             rsp_q, rsp_d;
  logic             ok;
  rsp_t             r;
  wr_t              wr;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = ovalid_q;
  assign rsp_o       = rsp_q;
  assign raddr_o     = cnt_q[IdxW-1:0];
  assign wr_o        = wr;

  always_comb begin
    state_d = state_q; req_d = req_q; cnt_d = cnt_q; rv_d = 1'b0; ridx_d = cnt_q[IdxW-1:0];
    valid_d = valid_q; hit_d = hit_q; free_d = free_q; pred_d = pred_q; top_d = top_q;
    hidx_d = hidx_q; fidx_d = fidx_q; hconn_d = hconn_q; pconn_d = pconn_q;
    tconn_d = tconn_q; pkey_d = pkey_q; tkey_d = tkey_q; any_d = any_q;
    ovalid_d = ovalid_q; rsp_d = rsp_q; ok = 1'b0; r = '0; wr = '0;
    if (ovalid_q && rsp_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d = req_i;
          req_d.conn = req_i.conn & ConnW'((1 << ConnBits) - 1);
          cnt_d = '0; hit_d = 1'b0; free_d = 1'b0; pred_d = 1'b0; top_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q != CntW'(Capacity)) begin
          rv_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else if (!rv_q) begin
          state_d = S_DONE;
        end
        if (rv_q) begin
          if (!valid_q[ridx_q]) begin
            if (!free_d) begin free_d = 1'b1; fidx_d = ridx_q; end
          end else begin
            if (rkey_i == req_q.key && !hit_q) begin
              hit_d = 1'b1; hidx_d = ridx_q; hconn_d = rconn_i;
            end
            if (!top_q || rkey_i > tkey_q) begin
              top_d = 1'b1; tkey_d = rkey_i; tconn_d = rconn_i;
            end
            if (rkey_i <= req_q.key && (!pred_q || rkey_i > pkey_q)) begin
              pred_d = 1'b1; pkey_d = rkey_i; pconn_d = rconn_i;
            end
          end
        end
      end
      S_DONE: begin
        if (!ovalid_q || rsp_ready_i) begin
          r.status = StAbsent;
          case (req_q.op)
            OpInsert: begin
              if (hit_q) r.status = StPresent;
              else if (!free_q) r.status = StFull;
              else begin
                r.status = StOk; ok = 1'b1;
                wr.we = 1'b1; wr.addr = fidx_q; wr.key = req_q.key; wr.conn = req_q.conn;
                valid_d[fidx_q] = 1'b1;
              end
            end
            OpRemove: begin
              if (hit_q && hconn_q == req_q.conn) begin
                r.status = StOk; ok = 1'b1; valid_d[hidx_q] = 1'b0;
              end
            end
            OpFind: begin
              if (top_q) begin
                r.status = StOk; r.found = 1'b1;
                r.found_conn = pred_q ? pconn_q : tconn_q;
              end
            end
            default: r.status = StAbsent;
          endcase
          if (req_q.last) begin
            r.set_ok = any_q | ok; any_d = 1'b0;
          end else begin
            any_d = any_q | ok;
          end
          rsp_d = r; ovalid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rv_q <= 1'b0; valid_q <= '0;
      any_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rv_q <= rv_d; valid_q <= valid_d;
      any_q <= any_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; ridx_q <= ridx_d; hit_q <= hit_d; free_q <= free_d;
    pred_q <= pred_d; top_q <= top_d; hidx_q <= hidx_d; fidx_q <= fidx_d;
    hconn_q <= hconn_d; pconn_q <= pconn_d; tconn_q <= tconn_d;
    pkey_q <= pkey_d; tkey_q <= tkey_d; rsp_q <= rsp_d;
  end
endmodule

// File: rtl/core/route_table_predecessor_lookup_core.sv
// Top level of the route table predecessor lookup core.
//  channel | dir | tdata (low bit up)           | tuser / tlast
//  s_axis  | in  | op[1:0] key[65:2] conn[73:66] | tlast = last_of_set
//  m_axis  | out | status[1:0] found_conn[9:2]  | tuser = {set_ok, found}
// The result follows the scan: one memory read per slot, paced by the single read
// port of the entry memory, then the last read drains and the finish step writes
// the result. The next item is accepted only once the core is back in idle.
// Reset clears all slot valid bits at once; no clearing pass.
// One item is in work at a time; a waiting result holds only the finish step.
module route_table_predecessor_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // op, key, conn, zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, found_conn, zero fill
  output logic [1:0]  m_axis_tuser   // found, set_ok
);
  import rtpl_pkg::*;

  req_t             req;
  rsp_t             rsp;
  wr_t              wr;
  logic [IdxW-1:0]  raddr;
  logic [KeyW-1:0]  rkey;
  logic [ConnW-1:0] rconn;

  assign req.op   = s_axis_tdata[1:0];
  assign req.key  = s_axis_tdata[65:2];
  assign req.conn = s_axis_tdata[73:66];
  assign req.last = s_axis_tlast;

  assign m_axis_tdata = {6'd0, rsp.found_conn, rsp.status};
  assign m_axis_tuser = {rsp.set_ok, rsp.found};

  rtpl_ram u_ram (
    .clk_i, .wr_i(wr), .raddr_i(raddr), .rkey_o(rkey), .rconn_o(rconn)
  );

  rtpl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready), .req_i(req),
    .rsp_valid_o(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_o(rsp),
    .wr_o(wr), .raddr_o(raddr), .rkey_i(rkey), .rconn_i(rconn)
  );
endmodule

// File: test/testbench.sv
// Self-checking testbench for the route table predecessor lookup core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpl_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam logic [1:0]  OpBad       = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [ConnW-1:0] found_conn;
    logic             found;
    logic             set_ok;
  } route_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  route_table_predecessor_lookup_core u_dut (.*);

  always #1 clk_i = ~clk_i;

  req_t        pending_q[$];
  route_rsp_t  expected_q[$];
  logic [63:0] tbl_key[Capacity];
  logic [7:0]  tbl_conn[Capacity];
  logic        tbl_valid[Capacity];
  logic        list_any_ok;
  logic [63:0] used_ids[$];
  int          errors;
  int          n_sent, n_checked, n_found, n_full;
  int unsigned cycles;
  bit          quiet_side;

  function automatic route_rsp_t route_predict(req_t r);
    route_rsp_t p;
    int s, pred, top;
    logic ok;
    p = '{status: StAbsent, found_conn: '0, found: 1'b0, set_ok: 1'b0};
    ok = 1'b0;
    s = -1;
    for (int i = 0; i < Capacity; i++)
      if (s < 0 && tbl_valid[i] && tbl_key[i] == r.key) s = i;
    if (r.op == OpInsert) begin
      if (s >= 0) begin
        p.status = StPresent;
      end else begin
        for (int i = Capacity - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
        if (s < 0) begin
          p.status = StFull;
        end else begin
          tbl_key[s] = r.key;
          tbl_conn[s] = r.conn;
          tbl_valid[s] = 1'b1;
          p.status = StOk;
          ok = 1'b1;
        end
      end
    end else if (r.op == OpRemove) begin
      if (s >= 0 && tbl_conn[s] == r.conn) begin
        tbl_valid[s] = 1'b0;
        p.status = StOk;
        ok = 1'b1;
      end
    end else if (r.op == OpFind) begin
      pred = -1;
      top = -1;
      for (int i = 0; i < Capacity; i++) begin
        if (tbl_valid[i]) begin
          if (top < 0 || tbl_key[i] > tbl_key[top]) top = i;
          if (tbl_key[i] <= r.key && (pred < 0 || tbl_key[i] > tbl_key[pred])) pred = i;
        end
      end
      if (top >= 0) begin
        p.status = StOk;
        p.found = 1'b1;
        p.found_conn = tbl_conn[pred >= 0 ? pred : top];
      end
    end
    if (ok) list_any_ok = 1'b1;
    if (r.last) begin
      p.set_ok = list_any_ok;
      list_any_ok = 1'b0;
    end
    return p;
  endfunction

  function automatic bit idle_now();
    return !quiet_side && ($urandom_range(99) < 32);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(route_predict(pending_q.pop_front()));
        n_sent++;
      end
      if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if ((s_axis_tvalid && !s_axis_tready) || !idle_now()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, pending_q[0].conn, pending_q[0].key, pending_q[0].op};
        s_axis_tlast <= pending_q[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    route_rsp_t w;
    route_rsp_t g;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        g = '{status: m_axis_tdata[1:0], found_conn: m_axis_tdata[9:2],
              found: m_axis_tuser[0], set_ok: m_axis_tuser[1]};
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %p", g);
          errors++;
        end else begin
          w = expected_q.pop_front();
          n_checked++;
          if (w.found) n_found++;
          if (w.status == StFull) n_full++;
          if (g.status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, g.status); errors++;
          end
          if (g.found_conn !== w.found_conn) begin
            $error("found_conn: expected %0d, got %0d", w.found_conn, g.found_conn);
            errors++;
          end
          if (g.found !== w.found) begin
            $error("found: expected %0d, got %0d", w.found, g.found); errors++;
          end
          if (g.set_ok !== w.set_ok) begin
            $error("set_ok: expected %0d, got %0d", w.set_ok, g.set_ok); errors++;
          end
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand_id();
    if (used_ids.size() > 0 && $urandom_range(2) == 0)
      return used_ids[$urandom_range(used_ids.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic add_req(logic [1:0] op, logic [63:0] key, logic [7:0] conn, logic last);
    pending_q.push_back('{op: op, key: key, conn: conn, last: last});
    if (op == OpInsert) used_ids.push_back(key);
  endtask

  initial begin
    logic [7:0] c;
    int len;
    cycles = 0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_found = 0;
    n_full = 0;
    list_any_ok = 1'b0;
    quiet_side = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_conn[i] = '0;
    end
    // directed: empty find, extremes, duplicates, owner checks, invalid op
    add_req(OpFind, 64'd5, 8'd0, 1'b1);
    add_req(OpRemove, 64'd5, 8'd0, 1'b1);
    add_req(OpInsert, 64'd0, 8'hFF, 1'b0);
    add_req(OpInsert, '1, 8'h00, 1'b0);
    add_req(OpInsert, 64'h8000_0000_0000_0000, 8'hA5, 1'b1);
    add_req(OpInsert, 64'd0, 8'h11, 1'b1);
    add_req(OpFind, 64'd0, 8'h00, 1'b0);
    add_req(OpFind, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0);
    add_req(OpFind, '1, 8'h00, 1'b1);
    add_req(OpRemove, 64'd0, 8'h01, 1'b1);
    add_req(OpRemove, 64'd0, 8'hFF, 1'b0);
    add_req(OpFind, 64'd3, 8'h00, 1'b1);
    add_req(OpBad, 64'd3, 8'h5A, 1'b1);
    add_req(OpInsert, 64'd3, 8'h5A, 1'b0);
    add_req(OpBad, 64'd9, 8'h00, 1'b1);
    add_req(OpFind, 64'h5555_AAAA_5555_AAAA, 8'h00, 1'b1);
    for (int i = 0; i < Capacity; i++)
      add_req(OpInsert, 64'h1000 + 64'(i) * 64'h100, 8'(i), 1'(i % 8 == 7));
    add_req(OpInsert, 64'h77, 8'h1, 1'b1);
    add_req(OpInsert, 64'h1000, 8'h1, 1'b1);
    add_req(OpFind, 64'h1050, 8'h0, 1'b1);
    for (int i = 0; i < Capacity + 4; i++)
      add_req(OpRemove, 64'h1000 + 64'(i) * 64'h100, 8'(i), 1'b1);
    // random lists per connection, mixed with finds and noise
    while (pending_q.size() < 1000) begin
      c = 8'($urandom);
      len = $urandom_range(1, 8);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: add_req(OpInsert, rand_id(), c, 1'(j == len - 1));
          4, 5: add_req(OpRemove, rand_id(), $urandom_range(3) == 0 ? 8'($urandom) : c,
                        1'(j == len - 1));
          6, 7, 8: add_req(OpFind, {$urandom, $urandom}, 8'($urandom), 1'(j == len - 1));
          default: add_req(OpBad, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
        endcase
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_sent > 400);
    quiet_side = 1'b1;
    wait (n_sent > 600);
    quiet_side = 1'b0;
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d items, %0d results checked, %0d finds hit, %0d full-table inserts",
             n_sent, n_checked, n_found, n_full);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: route_table_predecessor_lookup_core.f
rtl/core/rtpl_pkg.sv
rtl/core/rtpl_ram.sv
rtl/core/rtpl_ctrl.sv
rtl/core/route_table_predecessor_lookup_core.sv
test/testbench.sv
